// ===== hdl/mfb_pkg.sv =====
// Package for the one-bit-per-pixel double-buffered frame store.
// Holds the field widths, default geometry, operation codes and register indexes.
// Has no dependencies; every other file imports it.
package mfb_pkg;

   localparam int DEF_SCREEN_COLS = 240;
   localparam int DEF_SCREEN_ROWS = 320;
   localparam int DEF_FRAME_BYTES = 9600;

   localparam int FUNC_W    = 2;
   localparam int COORD_W   = 10;
   localparam int INDEX_W   = 14;
   localparam int COLOR_W   = 16;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FILL_SCREEN = 2'd0,
      FUNC_FILL_RECT   = 2'd1,
      FUNC_READ_BYTE   = 2'd2,
      FUNC_SWAP        = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_COLOR   = 2'd0,
      CSR_CLEAR_COLOR = 2'd1
   } csr_index_type;

   localparam logic [COLOR_W-1:0] SET_COLOR_RESET   = 16'h0000;
   localparam logic [COLOR_W-1:0] CLEAR_COLOR_RESET = 16'hFFFF;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   localparam logic [2:0] LAST_PIXEL_SLOT = 3'd7;

endpackage

// ===== hdl/mfb_ifs.sv =====
// Valid/ready channel interfaces for the frame store: commands, pixel words
// and register writes. Each has a source and a sink modport.
// Depends on mfb_pkg for the field widths.
interface mfb_req_if import mfb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic               pixel_on;
   logic [COORD_W-1:0] rect_x;
   logic [COORD_W-1:0] rect_y;
   logic [COORD_W-1:0] rect_width;
   logic [COORD_W-1:0] rect_height;
   logic [INDEX_W-1:0] byte_index;

   modport source (output valid, func, pixel_on, rect_x, rect_y, rect_width, rect_height,
                   byte_index, input ready);
   modport sink   (input valid, func, pixel_on, rect_x, rect_y, rect_width, rect_height,
                   byte_index, output ready);
endinterface

interface mfb_rsp_if import mfb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_pixel;

   modport source (output valid, pixel_color, last_pixel, input ready);
   modport sink   (input valid, pixel_color, last_pixel, output ready);
endinterface

interface mfb_csr_if import mfb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COLOR_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mono_framebuffer_rect_fill.sv =====
// Double-buffered 1bpp frame store with screen fill, rectangle fill, byte readout
// and buffer swap. Top level; depends on mfb_pkg and the channel interfaces.
//
// Commands arrive on req, one word each. Pixel colors leave on rsp, and the two
// color registers are written on csr, which is always ready.
// After reset the block sweeps both buffers to zero, one byte per cycle;
// req.ready is held low until the sweep is done.
// Command sequencing in the byte store:
//   swap:         toggles which buffer is drawn into and which is shown.
//   fill screen:  every byte of the draw buffer, one byte written per cycle.
//   fill rect:    a setup step, then per row a row step and a read and a write per
//                 byte touched, since each byte is read, modified and written back.
//   readout:      byte fetched from the shown buffer, then eight words at one per cycle
//                 while rsp is ready, the eighth with last_pixel set.
// The eight words of a readout sit in an output shift register. While rsp is
// stalled, further fills and swaps are still taken; a new readout waits until
// the previous byte has been fully delivered.
module mono_framebuffer_rect_fill import mfb_pkg::*; #(
   parameter int SCREEN_COLS = DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
   parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
   input logic        clock,
   input logic        reset,
   mfb_req_if.sink    req,
   mfb_rsp_if.source  rsp,
   mfb_csr_if.sink    csr
);

   localparam int STORE_BYTES = 2 * FRAME_BYTES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int LIN_W       = $clog2(SCREEN_ROWS * SCREEN_COLS + 1);
   localparam int POS_W       = (LIN_W > ADDR_W + 1) ? LIN_W : ADDR_W + 1;
   localparam int CMP_W       = (POS_W > INDEX_W) ? POS_W : INDEX_W;
   localparam int SPAN_W      = COORD_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCREEN,
      ST_RECT_SETUP,
      ST_RECT_ROW,
      ST_RECT_READ,
      ST_RECT_WRITE,
      ST_READ_WAIT
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic                 front_ff, front_in;
   logic [COLOR_W-1:0]   set_color_ff, set_color_in;
   logic [COLOR_W-1:0]   clear_color_ff, clear_color_in;
   logic                 emit_busy_ff, emit_busy_in;
   logic [2:0]           emit_cnt_ff, emit_cnt_in;

   logic                 on_ff, on_in;
   logic [COORD_W-1:0]   col_start_ff, col_start_in;
   logic [COORD_W-1:0]   width_ff, width_in;
   logic [COORD_W-1:0]   height_ff, height_in;
   logic [SPAN_W-1:0]    col_end_ff, col_end_in;
   logic [SPAN_W-1:0]    row_ff, row_in;
   logic [SPAN_W-1:0]    row_end_ff, row_end_in;
   logic [POS_W-1:0]     row_base_ff, row_base_in;
   logic [POS_W-1:0]     span_lo_ff, span_lo_in;
   logic [POS_W-1:0]     span_hi_ff, span_hi_in;
   logic [POS_W-1:0]     byte_ff, byte_in;
   logic [POS_W-1:0]     last_byte_ff, last_byte_in;
   logic [7:0]           emit_bits_ff, emit_bits_in;

   logic [7:0]           mem [STORE_BYTES];
   logic [7:0]           rd_data_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_wa, mem_ra;
   logic [7:0]           mem_wd;

   logic                 req_accept, rsp_accept, csr_accept;
   logic                 emit_load;
   logic [7:0]           emit_load_bits;
   logic [POS_W-1:0]     draw_base;
   logic [CMP_W-1:0]     show_base;
   logic                 index_in_range;
   logic                 byte_in_frame;
   logic [SPAN_W-1:0]    col_sum, row_sum, col_end_c, row_end_c;
   logic                 rect_empty;
   logic [7:0]           rect_mask;

   assign req.ready  = (state_ff == ST_IDLE) &&
                       !(emit_busy_ff && (req.func == FUNC_READ_BYTE));
   assign req_accept = req.valid && req.ready;
   assign rsp_accept = rsp.valid && rsp.ready;
   assign csr.ready  = 1'b1;
   assign csr_accept = csr.valid && csr.ready;

   assign rsp.valid       = emit_busy_ff;
   assign rsp.pixel_color = emit_bits_ff[7] ? set_color_ff : clear_color_ff;
   assign rsp.last_pixel  = (emit_cnt_ff == LAST_PIXEL_SLOT);

   assign draw_base      = front_ff ? POS_W'(FRAME_BYTES) : '0;
   assign show_base      = front_ff ? '0 : CMP_W'(FRAME_BYTES);
   assign index_in_range = CMP_W'(req.byte_index) < CMP_W'(FRAME_BYTES);
   assign byte_in_frame  = byte_ff < POS_W'(FRAME_BYTES);

   assign col_sum    = SPAN_W'(col_start_ff) + SPAN_W'(width_ff);
   assign row_sum    = row_ff + SPAN_W'(height_ff);
   assign col_end_c  = (col_sum > SPAN_W'(SCREEN_COLS)) ? SPAN_W'(SCREEN_COLS) : col_sum;
   assign row_end_c  = (row_sum > SPAN_W'(SCREEN_ROWS)) ? SPAN_W'(SCREEN_ROWS) : row_sum;
   assign rect_empty = (col_end_c <= SPAN_W'(col_start_ff)) || (row_end_c <= row_ff);

   always_comb begin
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int k = 0; k < 8; k++) begin
         pos = {byte_ff[POS_W-4:0], 3'(k)};
         rect_mask[7-k] = (pos >= span_lo_ff) && (pos < span_hi_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      front_in       = front_ff;
      set_color_in   = set_color_ff;
      clear_color_in = clear_color_ff;
      emit_busy_in   = emit_busy_ff;
      emit_cnt_in    = emit_cnt_ff;
      on_in          = on_ff;
      col_start_in   = col_start_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      col_end_in     = col_end_ff;
      row_in         = row_ff;
      row_end_in     = row_end_ff;
      row_base_in    = row_base_ff;
      span_lo_in     = span_lo_ff;
      span_hi_in     = span_hi_ff;
      byte_in        = byte_ff;
      last_byte_in   = last_byte_ff;
      emit_bits_in   = emit_bits_ff;
      mem_we         = 1'b0;
      mem_wa         = '0;
      mem_wd         = BYTE_ZEROS;
      mem_re         = 1'b0;
      mem_ra         = '0;
      emit_load      = 1'b0;
      emit_load_bits = rd_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = sweep_ff;
            if (sweep_ff == ADDR_W'(STORE_BYTES - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (func_type'(req.func))
                  FUNC_FILL_SCREEN: begin
                     on_in    = req.pixel_on;
                     state_in = ST_SCREEN;
                  end
                  FUNC_FILL_RECT: begin
                     on_in        = req.pixel_on;
                     col_start_in = req.rect_x;
                     row_in       = SPAN_W'(req.rect_y);
                     width_in     = req.rect_width;
                     height_in    = req.rect_height;
                     state_in     = ST_RECT_SETUP;
                  end
                  FUNC_READ_BYTE: begin
                     if (index_in_range) begin
                        mem_re   = 1'b1;
                        mem_ra   = ADDR_W'(show_base + CMP_W'(req.byte_index));
                        state_in = ST_READ_WAIT;
                     end else begin
                        emit_load      = 1'b1;
                        emit_load_bits = BYTE_ZEROS;
                     end
                  end
                  default: begin
                     front_in = ~front_ff;
                  end
               endcase
            end
         end
         ST_SCREEN: begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(draw_base + POS_W'(sweep_ff));
            mem_wd = on_ff ? BYTE_ONES : BYTE_ZEROS;
            if (sweep_ff == ADDR_W'(FRAME_BYTES - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_RECT_SETUP: begin
            col_end_in  = col_end_c;
            row_end_in  = row_end_c;
            row_base_in = POS_W'(int'(row_ff) * SCREEN_COLS);
            state_in    = rect_empty ? ST_IDLE : ST_RECT_ROW;
         end
         ST_RECT_ROW: begin
            span_lo_in   = row_base_ff + POS_W'(col_start_ff);
            span_hi_in   = row_base_ff + POS_W'(col_end_ff);
            byte_in      = (row_base_ff + POS_W'(col_start_ff)) >> 3;
            last_byte_in = (row_base_ff + POS_W'(col_end_ff) - POS_W'(1)) >> 3;
            state_in     = ST_RECT_READ;
         end
         ST_RECT_READ: begin
            mem_re   = byte_in_frame;
            mem_ra   = ADDR_W'(draw_base + byte_ff);
            state_in = ST_RECT_WRITE;
         end
         ST_RECT_WRITE: begin
            mem_we = byte_in_frame;
            mem_wa = ADDR_W'(draw_base + byte_ff);
            mem_wd = on_ff ? (rd_data_ff | rect_mask) : (rd_data_ff & ~rect_mask);
            if (byte_ff == last_byte_ff) begin
               if (row_ff + SPAN_W'(1) == row_end_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in      = row_ff + SPAN_W'(1);
                  row_base_in = row_base_ff + POS_W'(SCREEN_COLS);
                  state_in    = ST_RECT_ROW;
               end
            end else begin
               byte_in  = byte_ff + POS_W'(1);
               state_in = ST_RECT_READ;
            end
         end
         ST_READ_WAIT: begin
            emit_load = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit_load) begin
         emit_busy_in = 1'b1;
         emit_cnt_in  = '0;
         emit_bits_in = emit_load_bits;
      end else if (rsp_accept) begin
         emit_cnt_in  = emit_cnt_ff + 3'd1;
         emit_bits_in = {emit_bits_ff[6:0], 1'b0};
         if (emit_cnt_ff == LAST_PIXEL_SLOT) begin
            emit_busy_in = 1'b0;
         end
      end

      if (csr_accept) begin
         if (csr.index == CSR_SET_COLOR) begin
            set_color_in = csr.data;
         end else if (csr.index == CSR_CLEAR_COLOR) begin
            clear_color_in = csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         sweep_ff       <= '0;
         front_ff       <= 1'b0;
         set_color_ff   <= SET_COLOR_RESET;
         clear_color_ff <= CLEAR_COLOR_RESET;
         emit_busy_ff   <= 1'b0;
         emit_cnt_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         front_ff       <= front_in;
         set_color_ff   <= set_color_in;
         clear_color_ff <= clear_color_in;
         emit_busy_ff   <= emit_busy_in;
         emit_cnt_ff    <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      on_ff        <= on_in;
      col_start_ff <= col_start_in;
      width_ff     <= width_in;
      height_ff    <= height_in;
      col_end_ff   <= col_end_in;
      row_ff       <= row_in;
      row_end_ff   <= row_end_in;
      row_base_ff  <= row_base_in;
      span_lo_ff   <= span_lo_in;
      span_hi_ff   <= span_hi_in;
      byte_ff      <= byte_in;
      last_byte_ff <= last_byte_in;
      emit_bits_ff <= emit_bits_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("command taken during the clearing sweep");

   a_emit_load_free: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> !emit_busy_ff)
      else $error("readout byte loaded while the previous one is still being sent");

   a_last_word_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp.last_pixel) |=> !emit_busy_ff)
      else $error("output still busy after the last word of a byte");

   a_rect_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RECT_WRITE) |-> (rect_mask != '0))
      else $error("rectangle write with an empty pixel mask");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_wa) < 32'(STORE_BYTES)))
      else $error("byte store written beyond its depth");

endmodule

// ===== test/mfb_readout_check.sv =====
// Checker for the double-buffered 1bpp frame store: it watches the command,
// pixel and register channels, keeps a shadow of both buffers and compares
// every pixel word. Depends on mfb_pkg and the channel interfaces.
`timescale 1ns / 1ps

module mfb_readout_check import mfb_pkg::*; #(
   parameter int SCREEN_COLS = DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
   parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
   input  logic clock,
   input  logic reset,
   mfb_req_if   req,
   mfb_rsp_if   rsp,
   mfb_csr_if   csr,
   output int   mismatches,
   output int   pending_words
);

   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_word_type;

   pixel_word_type     words_due[$];
   pixel_word_type     due;
   logic [7:0]         shadow_store [2*FRAME_BYTES];
   logic               draw_sel;
   logic [COLOR_W-1:0] set_color;
   logic [COLOR_W-1:0] clear_color;
   int                 base;
   int                 x_end;
   int                 y_end;
   int                 lin;
   logic [7:0]         mask;
   logic [7:0]         fetched;

   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_store[i]) shadow_store[i] = BYTE_ZEROS;
         draw_sel = 1'b0;
         set_color = SET_COLOR_RESET;
         clear_color = CLEAR_COLOR_RESET;
         words_due.delete();
         mismatches = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (words_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected pixel word, expected none, got color %h last %b",
                        $time, rsp.pixel_color, rsp.last_pixel);
            end else begin
               due = words_due.pop_front();
               if (rsp.pixel_color !== due.color) begin
                  mismatches++;
                  $display("%0t: pixel_color expected %h, got %h",
                           $time, due.color, rsp.pixel_color);
               end
               if (rsp.last_pixel !== due.last) begin
                  mismatches++;
                  $display("%0t: last_pixel expected %b, got %b",
                           $time, due.last, rsp.last_pixel);
               end
            end
         end
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_SET_COLOR) begin
               set_color = csr.data;
            end else if (csr.index == CSR_CLEAR_COLOR) begin
               clear_color = csr.data;
            end
         end
         if (req.valid && req.ready) begin
            base = draw_sel ? FRAME_BYTES : 0;
            case (func_type'(req.func))
               FUNC_FILL_SCREEN: begin
                  for (int i = 0; i < FRAME_BYTES; i++)
                     shadow_store[base + i] = req.pixel_on ? BYTE_ONES : BYTE_ZEROS;
               end
               FUNC_FILL_RECT: begin
                  x_end = int'(req.rect_x) + int'(req.rect_width);
                  y_end = int'(req.rect_y) + int'(req.rect_height);
                  if (x_end > SCREEN_COLS) x_end = SCREEN_COLS;
                  if (y_end > SCREEN_ROWS) y_end = SCREEN_ROWS;
                  for (int row = int'(req.rect_y); row < y_end; row++) begin
                     for (int col = int'(req.rect_x); col < x_end; col++) begin
                        lin = row * SCREEN_COLS + col;
                        if ((lin / 8) < FRAME_BYTES) begin
                           mask = 8'h80 >> (lin % 8);
                           if (req.pixel_on) begin
                              shadow_store[base + lin / 8] |= mask;
                           end else begin
                              shadow_store[base + lin / 8] &= ~mask;
                           end
                        end
                     end
                  end
               end
               FUNC_READ_BYTE: begin
                  fetched = BYTE_ZEROS;
                  if (req.byte_index < FRAME_BYTES)
                     fetched = shadow_store[FRAME_BYTES - base + int'(req.byte_index)];
                  for (int k = 0; k < 8; k++)
                     words_due.push_back(pixel_word_type'{
                        fetched[7-k] ? set_color : clear_color, k == LAST_PIXEL_SLOT});
               end
               FUNC_SWAP: begin
                  draw_sel = ~draw_sel;
               end
            endcase
         end
      end
      pending_words = words_due.size();
   end

endmodule

// ===== test/mono_framebuffer_rect_fill_test.sv =====
// Top of the frame store testbench: clock, reset, command and register
// stimulus, output stalls and the verdict. Depends on mfb_pkg, the channel
// interfaces, the block itself and mfb_readout_check.
`timescale 1ns / 1ps

module mono_framebuffer_rect_fill_test;
   import mfb_pkg::*;

   localparam int SETTLE_CYCLES = DEF_SCREEN_ROWS * (2 * (DEF_SCREEN_COLS / 8 + 1) + 1) + 16;

   typedef struct {
      func_type           func;
      logic               pixel_on;
      logic [COORD_W-1:0] rect_x;
      logic [COORD_W-1:0] rect_y;
      logic [COORD_W-1:0] rect_width;
      logic [COORD_W-1:0] rect_height;
      logic [INDEX_W-1:0] byte_index;
   } frame_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   pending_words;
   bit   steady;
   bit   front_tb;
   int   items_sent;
   int   big_left;
   int   flood_left;
   int   hot_x [2];
   int   hot_y [2];
   int   hot_w [2];
   int   hot_h [2];

   mfb_req_if req ();
   mfb_rsp_if rsp ();
   mfb_csr_if csr ();

   mono_framebuffer_rect_fill DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   mfb_readout_check readout_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .csr           (csr),
      .mismatches    (mismatches),
      .pending_words (pending_words)
   );

   always #1 clock = ~clock;

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic frame_cmd_type any_cmd(input func_type f);
      frame_cmd_type c;
      c.func = f;
      c.pixel_on = 1'($urandom());
      c.rect_x = COORD_W'($urandom());
      c.rect_y = COORD_W'($urandom());
      c.rect_width = COORD_W'($urandom());
      c.rect_height = COORD_W'($urandom());
      c.byte_index = INDEX_W'($urandom());
      return c;
   endfunction

   // Mostly bytes around the last area drawn into the display buffer, plus
   // random and out-of-range indexes.
   function automatic logic [INDEX_W-1:0] choose_index();
      int roll;
      int b;
      int col;
      int row;
      roll = $urandom_range(0, 99);
      if (roll < 15) return INDEX_W'($urandom_range(0, DEF_FRAME_BYTES - 1));
      if (roll < 30) return INDEX_W'($urandom_range(DEF_FRAME_BYTES, (1 << INDEX_W) - 1));
      b = front_tb ? 0 : 1;
      col = hot_x[b] + int'($urandom_range(0, hot_w[b] + 15)) - 8;
      row = hot_y[b] + int'($urandom_range(0, hot_h[b] - 1));
      if (col < 0) col = 0;
      if (col >= DEF_SCREEN_COLS) col = DEF_SCREEN_COLS - 1;
      return INDEX_W'((row * DEF_SCREEN_COLS + col) / 8);
   endfunction

   task automatic send_cmd(input frame_cmd_type c);
      int gap;
      int xe;
      int ye;
      gap = steady ? 0 : gap_len();
      repeat (gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.func <= c.func;
      req.pixel_on <= c.pixel_on;
      req.rect_x <= c.rect_x;
      req.rect_y <= c.rect_y;
      req.rect_width <= c.rect_width;
      req.rect_height <= c.rect_height;
      req.byte_index <= c.byte_index;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      items_sent++;
      case (c.func)
         FUNC_SWAP: front_tb = ~front_tb;
         FUNC_FILL_SCREEN: begin
            hot_x[front_tb] = 0;
            hot_y[front_tb] = 0;
            hot_w[front_tb] = DEF_SCREEN_COLS;
            hot_h[front_tb] = DEF_SCREEN_ROWS;
         end
         FUNC_FILL_RECT: begin
            xe = int'(c.rect_x) + int'(c.rect_width);
            ye = int'(c.rect_y) + int'(c.rect_height);
            if (xe > DEF_SCREEN_COLS) xe = DEF_SCREEN_COLS;
            if (ye > DEF_SCREEN_ROWS) ye = DEF_SCREEN_ROWS;
            if (xe > c.rect_x && ye > c.rect_y) begin
               hot_x[front_tb] = c.rect_x;
               hot_y[front_tb] = c.rect_y;
               hot_w[front_tb] = xe - c.rect_x;
               hot_h[front_tb] = ye - c.rect_y;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_op(input func_type f);
      send_cmd(any_cmd(f));
   endtask

   task automatic send_read(input logic [INDEX_W-1:0] index);
      frame_cmd_type c;
      c = any_cmd(FUNC_READ_BYTE);
      c.byte_index = index;
      send_cmd(c);
   endtask

   task automatic send_rect(input logic on, input int x, input int y, input int w, input int h);
      frame_cmd_type c;
      c = any_cmd(FUNC_FILL_RECT);
      c.pixel_on = on;
      c.rect_x = COORD_W'(x);
      c.rect_y = COORD_W'(y);
      c.rect_width = COORD_W'(w);
      c.rect_height = COORD_W'(h);
      send_cmd(c);
   endtask

   // Large rectangles cost up to a full screen of read-modify-write, so only a
   // few are allowed.
   task automatic random_rect();
      int x;
      int y;
      int w;
      int h;
      if (big_left > 0 && $urandom_range(0, 99) < 12) begin
         big_left--;
         x = $urandom_range(0, DEF_SCREEN_COLS - 1);
         y = $urandom_range(0, DEF_SCREEN_ROWS - 1);
         w = $urandom_range(0, (1 << COORD_W) - 1);
         h = $urandom_range(0, (1 << COORD_W) - 1);
      end else begin
         x = ($urandom_range(0, 99) < 85) ? $urandom_range(0, DEF_SCREEN_COLS - 1)
                                          : $urandom_range(0, (1 << COORD_W) - 1);
         y = ($urandom_range(0, 99) < 85) ? $urandom_range(0, DEF_SCREEN_ROWS - 1)
                                          : $urandom_range(0, (1 << COORD_W) - 1);
         h = $urandom_range(0, 16);
         w = ($urandom_range(0, 3) == 0) ? h : $urandom_range(0, 32);
      end
      send_rect(1'($urandom()), x, y, w, h);
   endtask

   task automatic draw_and_show();
      if (flood_left > 0 && $urandom_range(0, 99) < 15) begin
         flood_left--;
         send_op(FUNC_FILL_SCREEN);
      end
      repeat ($urandom_range(1, 3)) random_rect();
      send_op(FUNC_SWAP);
      repeat ($urandom_range(2, 5)) send_read(choose_index());
   endtask

   task automatic stray_item();
      case ($urandom_range(0, 3))
         0: random_rect();
         1: send_read(choose_index());
         2: send_op(FUNC_SWAP);
         default: begin
            if (flood_left > 0) begin
               flood_left--;
               send_op(FUNC_FILL_SCREEN);
            end else begin
               send_read(choose_index());
            end
         end
      endcase
   endtask

   task automatic random_phase(input int count);
      int stop;
      stop = items_sent + count;
      while (items_sent < stop) begin
         if ($urandom_range(0, 99) < 75) draw_and_show();
         else stray_item();
      end
   endtask

   // Holds the sender until every pixel word is back and any fill still in
   // progress has had time to finish.
   task automatic settle();
      req.valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_word(input logic [CSR_IDX_W-1:0] index, input logic [COLOR_W-1:0] data);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data <= data;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
   endtask

   task automatic load_colors(input logic [COLOR_W-1:0] set_value,
                              input logic [COLOR_W-1:0] clear_value);
      write_word(CSR_SET_COLOR, set_value);
      write_word(CSR_IDX_W'($urandom_range(CSR_CLEAR_COLOR + 1, (1 << CSR_IDX_W) - 1)),
                 COLOR_W'($urandom()));
      write_word(CSR_CLEAR_COLOR, clear_value);
      csr.valid <= 1'b0;
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            stall--;
         end else begin
            rsp.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall = gap_len();
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.func = FUNC_FILL_SCREEN;
      req.pixel_on = 1'b0;
      req.rect_x = '0;
      req.rect_y = '0;
      req.rect_width = '0;
      req.rect_height = '0;
      req.byte_index = '0;
      csr.valid = 1'b0;
      csr.index = CSR_SET_COLOR;
      csr.data = '0;
      steady = 1'b0;
      front_tb = 1'b0;
      items_sent = 0;
      big_left = 6;
      flood_left = 3;
      foreach (hot_x[b]) begin
         hot_x[b] = 0;
         hot_y[b] = 0;
         hot_w[b] = DEF_SCREEN_COLS;
         hot_h[b] = DEF_SCREEN_ROWS;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_read('0);
      send_cmd('{FUNC_FILL_SCREEN, 1'b1, '0, '0, '0, '0, '0});
      send_op(FUNC_SWAP);
      send_read('0);
      send_read(INDEX_W'(DEF_FRAME_BYTES - 1));
      send_read(INDEX_W'(DEF_FRAME_BYTES));
      send_read('1);
      send_cmd('{FUNC_FILL_SCREEN, 1'b0, '1, '1, '1, '1, '1});
      send_rect(1'b1, 3, 0, 10, 2);
      send_rect(1'b1, 235, 318, 1023, 1023);
      send_rect(1'b1, 1023, 5, 5, 5);
      send_rect(1'b1, 0, 1023, 3, 3);
      send_rect(1'b1, 50, 50, 0, 10);
      send_rect(1'b1, 50, 50, 10, 0);
      send_rect(1'b1, 100, 100, 16, 16);
      send_rect(1'b0, 104, 104, 8, 8);
      send_op(FUNC_SWAP);
      send_read('0);
      send_read(INDEX_W'(1));
      send_read(INDEX_W'(DEF_FRAME_BYTES - 1));
      send_read(INDEX_W'(100 * DEF_SCREEN_COLS / 8 + 12));
      send_read(INDEX_W'(104 * DEF_SCREEN_COLS / 8 + 13));

      settle();
      load_colors(16'hFFFF, 16'h0000);
      random_phase(24);
      settle();
      load_colors(COLOR_W'($urandom()), COLOR_W'($urandom()));
      steady = 1'b1;
      random_phase(24);
      steady = 1'b0;
      settle();
      load_colors(16'h0000, 16'h0000);
      random_phase(24);
      settle();
      load_colors(16'hFFFF, 16'hFFFF);
      random_phase(24);
      settle();

      if (mismatches == 0 && pending_words == 0) begin
         $display("PASS mono_framebuffer_rect_fill");
      end else begin
         $display("FAIL mono_framebuffer_rect_fill");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL mono_framebuffer_rect_fill");
      $finish;
   end

endmodule
